@@ sv/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg: shared definitions for the 4x4 matrix multiplier
// Request codes, chain tag type and default widths used by the top level
// and by the dot-product cells.
// ----------------------------------------------------------------------------
package mm4_pkg;

  // Matrix dimension and element index width.
  localparam int unsigned Dim  = 4;
  localparam int unsigned IdxW = 4;

  // Width of the value ports and defaults of the top-level parameters.
  localparam int unsigned ValW             = 32;
  localparam int unsigned DefaultDataWidth = 32;
  localparam int unsigned DefaultFracBits  = 16;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_MULTIPLY   = 2'd2,
    REQ_NONE       = 2'd3
  } req_e;

  // Control that travels with a partial sum along the chain of cells.
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;   // product position, column*4+row
  } tag_t;

endpackage

@@ sv/mm4_cell.sv @@
// ----------------------------------------------------------------------------
// mm4_cell: one multiply-accumulate cell of the dot-product chain
// Cell k holds column k of the left matrix and row k of the right matrix.
// A word entering with product position (col,row) picks up A[k][row] times
// B[col][k], added to the partial sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module mm4_cell #(
  parameter int unsigned ELEM_W = 32,
  parameter int unsigned SUM_W  = 66
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     wr_left_i,
  input  logic                     wr_right_i,
  input  logic [1:0]               wr_slot_i,
  input  logic [ELEM_W-1:0]        wr_data_i,
  input  mm4_pkg::tag_t            tag_i,
  input  logic signed [SUM_W-1:0]  sum_i,
  output mm4_pkg::tag_t            tag_o,
  output logic signed [SUM_W-1:0]  sum_o,
  output logic                     busy_o
);

  localparam int unsigned ProdW = 2 * ELEM_W;

  logic signed [ELEM_W-1:0] left_q  [mm4_pkg::Dim];
  logic signed [ELEM_W-1:0] right_q [mm4_pkg::Dim];

  mm4_pkg::tag_t            tag1_q;
  logic signed [SUM_W-1:0]  sum1_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_d;
  mm4_pkg::tag_t            tag2_q;
  logic signed [SUM_W-1:0]  sum2_q;
  logic signed [SUM_W-1:0]  sum2_d;

  // Operand storage, written by element loads and cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mm4_pkg::Dim; i++) begin
        left_q[i]  <= '0;
        right_q[i] <= '0;
      end
    end else begin
      if (wr_left_i) begin
        left_q[wr_slot_i] <= wr_data_i;
      end
      if (wr_right_i) begin
        right_q[wr_slot_i] <= wr_data_i;
      end
    end
  end

  // The row selects the left operand, the column the right operand.
  assign prod_d = left_q[tag_i.idx[1:0]] * right_q[tag_i.idx[3:2]];
  assign sum2_d = sum1_q + SUM_W'(prod_q);

  // Control of the two stages: product, then accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  // Data of the two stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q <= sum_i;
      prod_q <= prod_d;
      sum2_q <= sum2_d;
    end
  end

  assign tag_o  = tag2_q;
  assign sum_o  = sum2_q;
  assign busy_o = tag1_q.valid | tag2_q.valid;

endmodule

@@ sv/matrix_multiply_4x4.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_4x4: 4x4 signed fixed-point matrix product C = A*B
// Four chained multiply-accumulate cells form each product element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): each word is a request. Load
//   left and load right write one element, position column*4+row, and are
//   taken one per cycle when not stalled. A multiply request streams the
//   sixteen elements of A*B in column-major order on the output channel
//   (out_valid_o / out_stall_i); the sixteenth carries out_last_o. Request
//   code 3 is dropped.
//   After a multiply is accepted, the product elements appear one per cycle
//   while the output is not stalled. The input stalls while the
//   sixteen positions are issued into the four-cell chain and until the
//   chain has drained; each position passes through the two-stage cells
//   (multiply, then add) of all four cells and then the output register.
//   A stalled output freezes the whole chain and holds the output word.
//   Reset clears both matrices to zero and empties the chain.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 #(
  parameter int unsigned DATA_WIDTH = mm4_pkg::DefaultDataWidth,
  parameter int unsigned FRAC_BITS  = mm4_pkg::DefaultFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [mm4_pkg::IdxW-1:0]         elem_index_i,
  input  logic signed [mm4_pkg::ValW-1:0]  elem_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mm4_pkg::IdxW-1:0]         out_index_o,
  output logic signed [mm4_pkg::ValW-1:0]  out_value_o,
  output logic                             out_last_o
);

  // Stored elements keep at most the 32 bits of the input value.
  localparam int unsigned ElemW = (DATA_WIDTH < mm4_pkg::ValW) ? DATA_WIDTH : mm4_pkg::ValW;
  localparam int unsigned SumW  = 2 * ElemW + 2;

  logic                       in_accept;
  logic                       en;
  logic                       chain_busy;
  logic                       mul_active_q;
  logic                       mul_active_d;
  logic [mm4_pkg::IdxW-1:0]   cnt_q;
  logic [mm4_pkg::IdxW-1:0]   cnt_d;

  mm4_pkg::tag_t              tag_chain [mm4_pkg::Dim+1];
  logic signed [SumW-1:0]     sum_chain [mm4_pkg::Dim+1];
  logic [mm4_pkg::Dim-1:0]    cell_busy;

  logic signed [SumW-1:0]     shifted;
  logic [SumW-ElemW:0]        high_bits;
  logic signed [ElemW-1:0]    sat_value;

  logic                       out_valid_q;
  logic [mm4_pkg::IdxW-1:0]   out_index_q;
  logic signed [mm4_pkg::ValW-1:0] out_value_q;
  logic                       out_last_q;

  // The chain advances whenever the output register can take a word.
  assign en         = !out_valid_q || !out_stall_i;
  assign chain_busy = |cell_busy;
  assign in_stall_o = mul_active_q || chain_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Issue sequencer: sixteen product positions after a multiply request.
  always_comb begin
    mul_active_d = mul_active_q;
    cnt_d        = cnt_q;
    if (in_accept && req_type_i == mm4_pkg::REQ_MULTIPLY) begin
      mul_active_d = 1'b1;
      cnt_d        = '0;
    end else if (mul_active_q && en) begin
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        mul_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_active_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      mul_active_q <= mul_active_d;
      cnt_q        <= cnt_d;
    end
  end

  assign tag_chain[0].valid = mul_active_q;
  assign tag_chain[0].idx   = cnt_q;
  assign sum_chain[0]       = '0;

  // Chain of cells; cell k owns A column k and B row k.
  for (genvar k = 0; k < mm4_pkg::Dim; k++) begin : g_cell
    logic       wr_left;
    logic       wr_right;
    logic [1:0] wr_slot;

    assign wr_left  = in_accept && req_type_i == mm4_pkg::REQ_LOAD_LEFT &&
                      elem_index_i[3:2] == 2'(k);
    assign wr_right = in_accept && req_type_i == mm4_pkg::REQ_LOAD_RIGHT &&
                      elem_index_i[1:0] == 2'(k);
    assign wr_slot  = (req_type_i == mm4_pkg::REQ_LOAD_LEFT) ?
                      elem_index_i[1:0] : elem_index_i[3:2];

    mm4_cell #(
      .ELEM_W (ElemW),
      .SUM_W  (SumW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .wr_left_i  (wr_left),
      .wr_right_i (wr_right),
      .wr_slot_i  (wr_slot),
      .wr_data_i  (elem_value_i[ElemW-1:0]),
      .tag_i      (tag_chain[k]),
      .sum_i      (sum_chain[k]),
      .tag_o      (tag_chain[k+1]),
      .sum_o      (sum_chain[k+1]),
      .busy_o     (cell_busy[k])
    );
  end

  // Floor shift of the exact sum, then saturation to the element range.
  assign shifted   = sum_chain[mm4_pkg::Dim] >>> FRAC_BITS;
  assign high_bits = shifted[SumW-1:ElemW-1];

  always_comb begin
    if ((&high_bits) || !(|high_bits)) begin
      sat_value = shifted[ElemW-1:0];
    end else if (shifted[SumW-1]) begin
      sat_value = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ElemW-1){1'b1}}};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tag_chain[mm4_pkg::Dim].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_index_q <= tag_chain[mm4_pkg::Dim].idx;
      out_value_q <= mm4_pkg::ValW'(sat_value);
      out_last_q  <= &tag_chain[mm4_pkg::Dim].idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // A multiply request starts issuing at position zero.
  a_mul_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_type_i == mm4_pkg::REQ_MULTIPLY) |=> (mul_active_q && cnt_q == '0))
    else $error("multiply request did not start issue at position zero");

  // Issuing ends after the sixteenth position.
  a_mul_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_active_q && en && (&cnt_q)) |=> !mul_active_q)
    else $error("issue did not stop after the last position");

  // A new output word comes only from a valid word at the chain end.
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(tag_chain[mm4_pkg::Dim].valid))
    else $error("output word without a chain result");

  // Loads are never taken while the chain still reads the operands.
  a_no_load_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_busy |-> !in_accept)
    else $error("element load accepted while the chain is busy");

endmodule
